// ----- sv/assert_macros.svh -----
// Assertion macros shared by the rectangle fill engine RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define PCF_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be seen outside reset
`define PCF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ----- sv/pcf_pkg.sv -----
// Shared types and constants of the clipped rectangle fill engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcf_pkg;

  localparam int COORD_W   = 12;  // left, top, rect_width, rect_height
  localparam int DIM_W     = 9;   // buffer geometry registers
  localparam int COLOR_W   = 32;  // one pixel
  localparam int LIN_W     = 24;  // linear pixel index, covers 4096 x 4096
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'd1;

  // Item modes
  localparam logic MODE_FILL = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DISPATCH,
    S_FILL,
    S_RWAIT,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COLOR_W-1:0] fill_color;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               dropped;
  } result_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- sv/clipped_rectangle_fill.sv -----
// Sequence: an accepted item passes S_SETUP and S_DISPATCH, then S_RESULT if dropped or empty,
// S_RWAIT then S_RESULT for a pixel read, or S_FILL (one write per cycle) then S_RESULT for a fill.
// Throughput: one item at a time; the next item can be taken in the cycle after the
// result enters the output register.
// Reset: synchronous active-low rst_n clears control and sets geometry to 256 x 256;
// the pixel store is not cleared and holds nothing defined until written.
`default_nettype none
`include "assert_macros.svh"

module clipped_rectangle_fill #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  // Configuration write port
  input  wire                              cfg_we,
  input  wire  [pcf_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire  [pcf_pkg::DIM_W-1:0]        cfg_wdata,
  // Input items
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [79:0] in_tdata,   // left[11:0], top, rect_width, rect_height, fill_color
  input  wire  [0:0]  in_tuser,   // mode
  // Result items
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // pixel_value
  output logic [0:0]  out_tuser   // dropped
);
  import pcf_pkg::*;

  localparam int AREA = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (AREA > 1) ? $clog2(AREA) : 1;

  logic [DIM_W-1:0]   bw_r, bh_r;
  geom_t              geom;
  item_t              item;
  logic               res_valid, res_ready;
  result_t            res;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;
  logic               out_tvalid_r;
  logic [COLOR_W-1:0] out_data_r;
  logic               out_drop_r;

  // Geometry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= DIM_W'(256);
      bh_r <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BUFFER_WIDTH:  bw_r <= cfg_wdata;
        REG_BUFFER_HEIGHT: bh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp geometry to the store size
  always_comb begin
    geom.width  = ((COORD_W+1)'(bw_r) > (COORD_W+1)'(MAX_WIDTH))
                  ? DIM_W'(MAX_WIDTH) : bw_r;
    geom.height = ((COORD_W+1)'(bh_r) > (COORD_W+1)'(MAX_HEIGHT))
                  ? DIM_W'(MAX_HEIGHT) : bh_r;
  end

  // Unpack input item
  assign item.mode        = in_tuser[0];
  assign item.left        = in_tdata[11:0];
  assign item.top         = in_tdata[23:12];
  assign item.rect_width  = in_tdata[35:24];
  assign item.rect_height = in_tdata[47:36];
  assign item.fill_color  = in_tdata[79:48];

  pcf_seq #(.AW(AW)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  pcf_mem #(.AW(AW), .DEPTH(AREA)) u_mem (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Output register
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res.pixel_value;
      out_drop_r <= res.dropped;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_drop_r;

  `PCF_ASSERT_CLK(a_result_lands, (res_valid && res_ready) |=> out_tvalid_r, "result lost at output register")
  `PCF_ASSERT_CLK(a_drop_zero, (out_tvalid_r && out_drop_r) |-> (out_data_r == '0), "dropped item carries a pixel value")
  `PCF_ASSERT_CLK(a_geom_clamp, (geom.width == bw_r) || ((COORD_W+1)'(bw_r) > (COORD_W+1)'(MAX_WIDTH)), "width clamp wrong")

endmodule

`default_nettype wire

// ----- sv/pcf_mem.sv -----
// Single-port pixel store: one write or one registered read per cycle.
// Depends on pcf_pkg for the pixel width and the memory control type.
`default_nettype none

module pcf_mem #(
  parameter int AW    = 16,
  parameter int DEPTH = 65536
) (
  input  wire                           clk,
  input  pcf_pkg::mem_ctl_t             mem_ctl,
  input  wire  [AW-1:0]                 mem_addr,
  input  wire  [pcf_pkg::COLOR_W-1:0]   mem_wdata,
  output logic [pcf_pkg::COLOR_W-1:0]   mem_rdata
);
  import pcf_pkg::*;

  logic [COLOR_W-1:0] store_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      store_r[mem_addr] <= mem_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      mem_rdata <= store_r[mem_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pcf_seq.sv -----
// Item sequencer: clips the rectangle, walks its pixels one per cycle
// and issues reads. Depends on pcf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcf_seq #(
  parameter int AW = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  pcf_pkg::geom_t               geom,
  input  wire                          item_valid,
  output logic                         item_ready,
  input  pcf_pkg::item_t               item,
  output logic                         res_valid,
  input  wire                          res_ready,
  output pcf_pkg::result_t             res,
  output pcf_pkg::mem_ctl_t            mem_ctl,
  output logic [AW-1:0]                mem_addr,
  output logic [pcf_pkg::COLOR_W-1:0]  mem_wdata,
  input  wire  [pcf_pkg::COLOR_W-1:0]  mem_rdata
);
  import pcf_pkg::*;

  seq_state_t          state_r, state_nxt;
  item_t               item_r;
  logic                drop_r;
  logic [DIM_W-1:0]    dw_r, dh_r;
  logic [DIM_W-1:0]    col_r, row_r;
  logic [LIN_W-1:0]    pix_addr_r, row_start_r;
  logic [COLOR_W-1:0]  value_r;

  // Setup arithmetic on the latched item
  logic [COORD_W:0]    bw_x, bh_x, x_end, y_end;
  logic                drop_nxt;
  logic [DIM_W-1:0]    dw_nxt, dh_nxt;
  logic [LIN_W-1:0]    base_nxt;
  logic                last_col, last_row, empty_rect;

  assign bw_x  = (COORD_W+1)'(geom.width);
  assign bh_x  = (COORD_W+1)'(geom.height);
  assign x_end = {1'b0, item_r.left} + {1'b0, item_r.rect_width};
  assign y_end = {1'b0, item_r.top} + {1'b0, item_r.rect_height};

  always_comb begin
    drop_nxt = ({1'b0, item_r.left} >= bw_x) || ({1'b0, item_r.top} >= bh_x);
    dw_nxt   = (x_end > bw_x) ? DIM_W'(bw_x - {1'b0, item_r.left})
                              : DIM_W'(item_r.rect_width);
    dh_nxt   = (y_end > bh_x) ? DIM_W'(bh_x - {1'b0, item_r.top})
                              : DIM_W'(item_r.rect_height);
    // row start needs the full product width
    base_nxt = LIN_W'(item_r.top) * LIN_W'(geom.width) + LIN_W'(item_r.left);
  end

  assign last_col   = (col_r == dw_r - DIM_W'(1));
  assign last_row   = (row_r == dh_r - DIM_W'(1));
  assign empty_rect = (dw_r == '0) || (dh_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (item_valid) state_nxt = S_SETUP;
      S_SETUP:    state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (drop_r) begin
          state_nxt = S_RESULT;
        end else if (item_r.mode == MODE_READ) begin
          state_nxt = S_RWAIT;
        end else if (empty_rect) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_FILL:     if (last_col && last_row) state_nxt = S_RESULT;
      S_RWAIT:    state_nxt = S_RESULT;
      S_RESULT:   if (res_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    mem_ctl.we  = 1'b0;
    mem_ctl.re  = 1'b0;
    unique case (state_r)
      S_IDLE:     item_ready = 1'b1;
      S_DISPATCH: mem_ctl.re = !drop_r && (item_r.mode == MODE_READ);
      S_FILL:     mem_ctl.we = 1'b1;
      S_RESULT:   res_valid  = 1'b1;
      default:    ;
    endcase
  end

  assign mem_addr        = pix_addr_r[AW-1:0];
  assign mem_wdata       = item_r.fill_color;
  assign res.pixel_value = value_r;
  assign res.dropped     = drop_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: item latch, clip, pixel walk, read capture
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (item_valid) item_r <= item;
      end
      S_SETUP: begin
        drop_r      <= drop_nxt;
        dw_r        <= dw_nxt;
        dh_r        <= dh_nxt;
        pix_addr_r  <= base_nxt;
        row_start_r <= base_nxt;
        col_r       <= '0;
        row_r       <= '0;
      end
      S_DISPATCH: value_r <= '0;
      S_FILL: begin
        if (last_col) begin
          col_r       <= '0;
          row_r       <= row_r + DIM_W'(1);
          row_start_r <= row_start_r + LIN_W'(geom.width);
          pix_addr_r  <= row_start_r + LIN_W'(geom.width);
        end else begin
          col_r      <= col_r + DIM_W'(1);
          pix_addr_r <= pix_addr_r + LIN_W'(1);
        end
      end
      S_RWAIT: value_r <= mem_rdata;
      default: ;
    endcase
  end

  `PCF_ASSERT_NEVER(a_rw_exclusive, mem_ctl.we && mem_ctl.re, "read and write in one cycle")
  `PCF_ASSERT_CLK(a_read_then_wait, mem_ctl.re |=> (state_r == S_RWAIT), "read not followed by wait")
  `PCF_ASSERT_CLK(a_walk_in_rect, (state_r == S_FILL) |-> (col_r < dw_r && row_r < dh_r), "fill walk left the clipped rectangle")
  `PCF_ASSERT_CLK(a_no_dropped_fill, (state_r == S_FILL) |-> !drop_r, "dropped item writes pixels")

endmodule

`default_nettype wire

// ----- test/clipped_rectangle_fill_test.sv -----
// Self-checking testbench for the clipped rectangle fill engine.
// Predicts every result from its own copy of pixels and geometry; uses pcf_pkg.
module clipped_rectangle_fill_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  localparam int MAX_W          = 256;
  localparam int MAX_H          = 256;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 400;
  // longest quiet stretch of a good run is one full 256 x 256 fill
  localparam int WATCHDOG_LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [79:0]          in_tdata = '0;  // left, top, rect_width, rect_height, fill_color
  logic [0:0]           in_tuser = '0;  // mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;      // pixel_value
  logic [0:0]           out_tuser;      // dropped

  // Predicted block state
  logic [COLOR_W-1:0] pixel_mem [0:MAX_W*MAX_H-1];
  logic [DIM_W-1:0]   geom_w = 9'd256;
  logic [DIM_W-1:0]   geom_h = 9'd256;
  result_t            pending_results[$];

  int err_count;
  int item_count;
  int fill_count;
  int read_count;
  int drop_count;
  int geom_writes;
  int idle_cycles;
  int hold_len;
  bit burst;

  clipped_rectangle_fill u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register value as the block uses it: anything past the maximum is the maximum
  function automatic int unsigned used_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    return (32'(v) > lim) ? lim : 32'(v);
  endfunction

  // Apply one item to the predicted pixel store and return its result
  function automatic result_t apply_item(input item_t it);
    int unsigned bw, bh, x, y, w, h, dw, dh, idx;
    result_t res;
    bw  = used_dim(geom_w, MAX_W);
    bh  = used_dim(geom_h, MAX_H);
    x   = 32'(it.left);
    y   = 32'(it.top);
    w   = 32'(it.rect_width);
    h   = 32'(it.rect_height);
    res = '0;
    if (x >= bw || y >= bh) begin
      res.dropped = 1'b1;
    end else if (it.mode == MODE_FILL) begin
      // clip at the right and bottom edges
      dw = (x + w > bw) ? bw - x : w;
      dh = (y + h > bh) ? bh - y : h;
      for (int unsigned j = 0; j < dh; j++) begin
        for (int unsigned i = 0; i < dw; i++) begin
          idx = (y + j) * bw + x + i;
          if (idx < MAX_W * MAX_H) pixel_mem[idx] = it.fill_color;
        end
      end
    end else begin
      idx = y * bw + x;
      if (idx < MAX_W * MAX_H) res.pixel_value = pixel_mem[idx];
    end
    return res;
  endfunction

  function automatic item_t make_item(input logic mode, input int left, input int top,
                                      input int w, input int h, input logic [31:0] color);
    item_t it;
    it.mode        = mode;
    it.left        = left[COORD_W-1:0];
    it.top         = top[COORD_W-1:0];
    it.rect_width  = w[COORD_W-1:0];
    it.rect_height = h[COORD_W-1:0];
    it.fill_color  = color;
    return it;
  endfunction

  // Mostly in-buffer fills and reads; the rest are raw random fields
  function automatic item_t random_item();
    int unsigned bw, bh;
    int r;
    item_t it;
    bw             = used_dim(geom_w, MAX_W);
    bh             = used_dim(geom_h, MAX_H);
    it.mode        = 1'($urandom_range(0, 1));
    it.left        = COORD_W'($urandom_range(0, 4095));
    it.top         = COORD_W'($urandom_range(0, 4095));
    it.rect_width  = COORD_W'($urandom_range(0, 4095));
    it.rect_height = COORD_W'($urandom_range(0, 4095));
    it.fill_color  = $urandom();
    r = $urandom_range(0, 99);
    if (bw != 0 && bh != 0 && r >= 12) begin
      it.left = COORD_W'($urandom_range(0, bw - 1));
      it.top  = COORD_W'($urandom_range(0, bh - 1));
      if (r < 55) begin
        it.mode = MODE_FILL;
        // big requested sizes sit next to the edge so the clipped area stays small
        if ($urandom_range(0, 3) != 0) it.rect_width = COORD_W'($urandom_range(0, 8));
        else it.left = COORD_W'(bw - 1 - $urandom_range(0, (bw > 8) ? 7 : bw - 1));
        if ($urandom_range(0, 3) != 0) it.rect_height = COORD_W'($urandom_range(0, 8));
        else it.top = COORD_W'(bh - 1 - $urandom_range(0, (bh > 8) ? 7 : bh - 1));
      end else begin
        it.mode = MODE_READ;
      end
    end
    return it;
  endfunction

  function automatic int pause_len();
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got %08h want %08h", $time, what, got, want);
    err_count++;
  endtask

  // Offer one item after a random gap and record its expected result on accept
  task automatic send_item(input item_t it);
    int gap;
    result_t res;
    gap = pause_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {it.fill_color, it.rect_height, it.rect_width, it.top, it.left};
    in_tuser  = it.mode;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    res = apply_item(it);
    pending_results.push_back(res);
    item_count++;
    if (res.dropped) drop_count++;
    else if (it.mode == MODE_FILL) fill_count++;
    else read_count++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = REG_BUFFER_WIDTH;
    cfg_wdata = w[DIM_W-1:0];
    @(negedge clk);
    cfg_addr  = REG_BUFFER_HEIGHT;
    cfg_wdata = h[DIM_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    geom_w = w[DIM_W-1:0];
    geom_h = h[DIM_W-1:0];
    geom_writes++;
  endtask

  // Edges, clipping, empty and outside rectangles at the reset geometry
  task automatic test_corners_and_clipping();
    // first item covers every pixel, so later reads always hit written pixels
    send_item(make_item(MODE_FILL, 0, 0, 4095, 4095, 32'h1122_3344));
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 255, 255, 4095, 4095, 32'hFFFF_FFFF));
    send_item(make_item(MODE_READ, 256, 0, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 0, 256, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 4095, 4095, 0, 0, 32'h0));
    send_item(make_item(MODE_FILL, 256, 3, 4, 4, 32'hDEAD_BEEF));
    send_item(make_item(MODE_FILL, 0, 4095, 1, 1, 32'hDEAD_BEEF));
    // single pixel at the far corner
    send_item(make_item(MODE_FILL, 255, 255, 1, 1, 32'hFFFF_FFFF));
    send_item(make_item(MODE_READ, 255, 255, 0, 0, 32'h0));
    // zero width or height writes nothing and is not flagged
    send_item(make_item(MODE_FILL, 10, 10, 0, 5, 32'h0));
    send_item(make_item(MODE_FILL, 10, 10, 5, 0, 32'h0));
    send_item(make_item(MODE_READ, 10, 10, 0, 0, 32'h0));
    // clipped at both edges down to 6 x 4
    send_item(make_item(MODE_FILL, 250, 252, 100, 100, 32'hA5A5_5A5A));
    send_item(make_item(MODE_READ, 255, 255, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 249, 252, 0, 0, 32'h0));
    send_item(make_item(MODE_FILL, 3, 4, 2, 3, 32'h0000_0000));
    send_item(make_item(MODE_READ, 4, 6, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 5, 7, 0, 0, 32'h0));
  endtask

  // Short rows, empty buffer and oversized register values
  task automatic test_geometry_registers();
    set_geometry(16, 16);
    send_item(make_item(MODE_FILL, 1, 1, 2, 2, 32'hC0FF_EE00));
    send_item(make_item(MODE_READ, 2, 2, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 16, 0, 0, 0, 32'h0));
    set_geometry(0, 16);
    send_item(make_item(MODE_READ, 0, 0, 0, 0, 32'h0));
    send_item(make_item(MODE_FILL, 0, 0, 1, 1, 32'h1234_5678));
    set_geometry(511, 300);
    send_item(make_item(MODE_READ, 255, 255, 0, 0, 32'h0));
    send_item(make_item(MODE_READ, 256, 0, 0, 0, 32'h0));
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    set_geometry(256, 256);
    burst    = 1'b1;
    hold_len = HOLD_CYCLES;
    repeat (8) send_item(random_item());
    burst = 1'b0;
  endtask

  // Random traffic over a series of buffer geometries
  task automatic test_random_traffic();
    int w, h, count;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin w = 256; h = 256; end
        1: begin w = 1;   h = 1;   end
        2: begin w = 1;   h = 256; end
        3: begin w = 256; h = 1;   end
        4: begin w = 511; h = 300; end
        5: begin w = 0;   h = 64;  end
        default: begin
          w = $urandom_range(1, 256);
          h = $urandom_range(1, 256);
        end
      endcase
      set_geometry(w, h);
      count = (w == 0) ? 30 : 205;
      for (int n = 0; n < count; n++) begin
        if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
        send_item(random_item());
      end
      burst = 1'b0;
    end
  endtask

  // Result side: random stalls, compare against the oldest expectation
  initial begin : result_checker
    int stall;
    result_t want;
    @(posedge rst_n);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = pause_len();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, pixel_value", out_tdata, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.pixel_value)
          report_mismatch("pixel_value", out_tdata, want.pixel_value);
        if (out_tuser[0] !== want.dropped)
          report_mismatch("dropped", {31'h0, out_tuser[0]}, {31'h0, want.dropped});
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results pending",
                 idle_cycles, pending_results.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corners_and_clipping();
    test_geometry_registers();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d fills, %0d reads, %0d dropped, %0d geometry settings",
             item_count, fill_count, read_count, drop_count, geom_writes);
    $display("mismatches found: %0d", err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
